### sv/pblc_pkg.sv
package pblc_pkg;

	// input opcodes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RX    = 2'd1,
		OP_LED   = 2'd2,
		OP_SPARE = 2'd3
	} pblc_op_t;

	// configuration register indexes
	localparam logic CFG_HEAD   = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;

	// link commands
	localparam logic [7:0] CMD_LED    = 8'h01;
	localparam logic [7:0] CMD_POWER  = 8'h02;
	localparam logic [7:0] CMD_CHARGE = 8'h03;
	localparam logic [7:0] POWER_QUERY_DATA = 8'h01;

	localparam int unsigned LED_KINDS = 8;

	localparam logic [7:0]  HEAD_RESET   = 8'd165;
	localparam logic [30:0] PERIOD_RESET = 31'd10000;

	// work handed from front to back: up to two frames plus status after the item
	typedef struct packed {
		logic       has_poll;
		logic       has_led;
		logic [2:0] led_data;
		logic [7:0] head;
		logic [7:0] percent;
		logic [7:0] charging;
		logic [2:0] shown;
	} pblc_job_t;

endpackage

### sv/power_board_link_controller.sv
// Power board link controller.
// Input channel (in_valid/in_ready) takes one word per item: a tick, a byte
// received from the power board, or a set-LED request. Output channel
// (out_valid/out_ready) gives the result words of each item in order: the
// bytes to transmit (tx_valid 1, up to two 4-byte frames, poll query first),
// or one word with tx_valid 0 when an item sends nothing. last_of_run marks
// the final word of an item; status fields show registers after the item.
// The front stage executes an item in the cycle it is accepted and pushes a
// job into a two-entry queue; the back stage serializes it into an output
// register. The first word passes through the queue, the back stage's job
// register and the output register. Each item gives 1, 4 or 8 output words,
// one word per cycle from the back stage's serializer while out_ready allows.
// in_ready drops only when the queue holds two jobs, so a stalled receiver
// backs up into the queue and then the input; no word is lost or dropped.
// Config: cfg_we with cfg_index 0 (head byte) or 1 (poll period), while idle.
// Reset clears time, deadlines, LED, status and deframer, restores head
// 165 and poll period 10000, and empties the queue and output register.
module power_board_link_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  led_kind,
	input  logic [30:0] hold_ticks,
	input  logic        revert_enable,
	input  logic [2:0]  revert_kind,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_out,
	output logic        last_of_run,
	output logic [7:0]  battery_percent,
	output logic [7:0]  charging_flag,
	output logic [2:0]  shown_led
);

	pblc_pkg::pblc_job_t front_job, back_job;
	logic take, q_full, q_empty, q_pop;

	assign in_ready = !q_full;
	assign take     = in_valid && !q_full;

	pblc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.take          (take),
		.opcode        (opcode),
		.rx_byte       (rx_byte),
		.led_kind      (led_kind),
		.hold_ticks    (hold_ticks),
		.revert_enable (revert_enable),
		.revert_kind   (revert_kind),
		.job           (front_job)
	);

	pblc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.din    (front_job),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (back_job),
		.empty  (q_empty)
	);

	pblc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_job           (back_job),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_valid        (tx_valid),
		.tx_out          (tx_out),
		.last_of_run     (last_of_run),
		.battery_percent (battery_percent),
		.charging_flag   (charging_flag),
		.shown_led       (shown_led)
	);

endmodule

### sv/pblc_front.sv
module pblc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [30:0]         cfg_data,
	input  logic                take,
	input  logic [1:0]          opcode,
	input  logic [7:0]          rx_byte,
	input  logic [2:0]          led_kind,
	input  logic [30:0]         hold_ticks,
	input  logic                revert_enable,
	input  logic [2:0]          revert_kind,
	output pblc_pkg::pblc_job_t job
);

	typedef enum logic [1:0] {
		PH_HEAD = 2'd0,
		PH_CMD  = 2'd1,
		PH_DATA = 2'd2,
		PH_SUM  = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  head_q;
	logic [30:0] period_q;
	logic [31:0] now_q, now_d;
	logic [31:0] last_poll_q, last_poll_d;
	logic [31:0] target_q, target_d;   // last_poll + period
	logic [31:0] deadline_q, deadline_d;
	logic [2:0]  saved_q, saved_d;
	logic [2:0]  cur_q, cur_d;
	logic [7:0]  pct_q, pct_d;
	logic [7:0]  chg_q, chg_d;
	logic [7:0]  fb0_q, fb1_q, fb2_q;
	logic [7:0]  fb0_d, fb1_d, fb2_d;
	logic        has_poll, has_led;
	logic [2:0]  led_data;

	logic [31:0] now_inc, poll_diff, dl_diff;
	logic        poll_hit, rev_hit, dl_live;
	logic [7:0]  sum;

	assign now_inc   = now_q + 32'd1;
	assign poll_diff = now_inc - target_q;
	assign dl_diff   = now_inc - deadline_q;
	assign poll_hit  = ~poll_diff[31];
	assign dl_live   = (deadline_q != '0) && (deadline_q != '1);
	assign rev_hit   = dl_live && ~dl_diff[31];
	assign sum       = fb0_q + fb1_q + fb2_q;

	always_comb begin
		phase_d     = phase_q;
		now_d       = now_q;
		last_poll_d = last_poll_q;
		target_d    = target_q;
		deadline_d  = deadline_q;
		saved_d     = saved_q;
		cur_d       = cur_q;
		pct_d       = pct_q;
		chg_d       = chg_q;
		fb0_d       = fb0_q;
		fb1_d       = fb1_q;
		fb2_d       = fb2_q;
		has_poll    = 1'b0;
		has_led     = 1'b0;
		led_data    = '0;
		unique case (pblc_pkg::pblc_op_t'(opcode))
			pblc_pkg::OP_TICK: begin
				now_d = now_inc;
				if (poll_hit) begin
					has_poll    = 1'b1;
					last_poll_d = now_inc;
					target_d    = now_inc + {1'b0, period_q};
				end
				if (rev_hit && (32'(saved_q) < pblc_pkg::LED_KINDS)) begin
					has_led    = 1'b1;
					led_data   = saved_q;
					cur_d      = saved_q;
					saved_d    = '0;
					deadline_d = '0;
				end
			end
			pblc_pkg::OP_RX: begin
				unique case (phase_q)
					PH_HEAD: begin
						if (rx_byte == head_q) begin
							fb0_d   = head_q;
							phase_d = PH_CMD;
						end
					end
					PH_CMD: begin
						fb1_d   = rx_byte;
						phase_d = PH_DATA;
					end
					PH_DATA: begin
						fb2_d   = rx_byte;
						phase_d = PH_SUM;
					end
					PH_SUM: begin
						if (sum == rx_byte) begin
							if (fb1_q == pblc_pkg::CMD_POWER)
								pct_d = fb2_q;
							else if (fb1_q == pblc_pkg::CMD_CHARGE)
								chg_d = fb2_q;
						end
						phase_d = PH_HEAD;
					end
					default: phase_d = PH_HEAD;
				endcase
			end
			pblc_pkg::OP_LED: begin
				if (32'(led_kind) < pblc_pkg::LED_KINDS) begin
					has_led    = 1'b1;
					led_data   = led_kind;
					saved_d    = revert_kind;
					cur_d      = led_kind;
					deadline_d = revert_enable ? ({1'b0, hold_ticks} + now_q) : '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		job.has_poll = has_poll;
		job.has_led  = has_led;
		job.led_data = led_data;
		job.head     = head_q;
		job.percent  = pct_d;
		job.charging = chg_d;
		job.shown    = cur_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEAD;
			head_q      <= pblc_pkg::HEAD_RESET;
			period_q    <= pblc_pkg::PERIOD_RESET;
			now_q       <= '0;
			last_poll_q <= '0;
			target_q    <= {1'b0, pblc_pkg::PERIOD_RESET};
			deadline_q  <= '0;
			saved_q     <= '0;
			cur_q       <= '0;
			pct_q       <= '0;
			chg_q       <= '0;
		end else if (cfg_we) begin
			// config must only arrive while idle; the user keeps to this, the block does not enforce it
			if (cfg_index == pblc_pkg::CFG_HEAD) begin
				head_q <= cfg_data[7:0];
			end else begin
				period_q <= cfg_data;
				target_q <= last_poll_q + {1'b0, cfg_data};
			end
		end else if (take) begin
			phase_q     <= phase_d;
			now_q       <= now_d;
			last_poll_q <= last_poll_d;
			target_q    <= target_d;
			deadline_q  <= deadline_d;
			saved_q     <= saved_d;
			cur_q       <= cur_d;
			pct_q       <= pct_d;
			chg_q       <= chg_d;
		end
	end

	// frame bytes: written before read, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			fb0_q <= fb0_d;
			fb1_q <= fb1_d;
			fb2_q <= fb2_d;
		end
	end

endmodule

### sv/pblc_queue.sv
module pblc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pblc_pkg::pblc_job_t din,
	output logic                full,
	input  logic                pop,
	output pblc_pkg::pblc_job_t dout,
	output logic                empty
);

	pblc_pkg::pblc_job_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/pblc_back.sv
module pblc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  pblc_pkg::pblc_job_t q_job,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                tx_valid,
	output logic [7:0]          tx_out,
	output logic                last_of_run,
	output logic [7:0]          battery_percent,
	output logic [7:0]          charging_flag,
	output logic [2:0]          shown_led
);

	pblc_pkg::pblc_job_t job_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       vld_q;
	logic       txv_q, last_q;
	logic [7:0] tx_q, pct_q, chg_q;
	logic [2:0] led_q;

	logic       load, none, sel_led, last_b;
	logic [7:0] cmd, dat, byte_b;

	assign load = !vld_q || out_ready;
	assign none = !job_q.has_poll && !job_q.has_led;
	// poll frame goes first when both are present
	assign sel_led = job_q.has_poll ? idx_q[2] : 1'b1;
	assign cmd = sel_led ? pblc_pkg::CMD_LED : pblc_pkg::CMD_POWER;
	assign dat = sel_led ? {5'd0, job_q.led_data} : pblc_pkg::POWER_QUERY_DATA;
	assign last_b = none ||
		((idx_q[1:0] == 2'd3) && (idx_q[2] || !(job_q.has_poll && job_q.has_led)));

	always_comb begin
		unique case (idx_q[1:0])
			2'd0:    byte_b = job_q.head;
			2'd1:    byte_b = cmd;
			2'd2:    byte_b = dat;
			default: byte_b = job_q.head + cmd + dat;
		endcase
	end

	// grab next job when idle or on the last word of the current one
	assign q_pop = load && !q_empty && (!busy_q || last_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			vld_q  <= 1'b0;
		end else if (load) begin
			vld_q <= busy_q;
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				busy_q <= !last_b;
				idx_q  <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_job;
		if (load && busy_q) begin
			txv_q  <= !none;
			tx_q   <= none ? 8'd0 : byte_b;
			last_q <= last_b;
			pct_q  <= job_q.percent;
			chg_q  <= job_q.charging;
			led_q  <= job_q.shown;
		end
	end

	assign out_valid       = vld_q;
	assign tx_valid        = txv_q;
	assign tx_out          = tx_q;
	assign last_of_run     = last_q;
	assign battery_percent = pct_q;
	assign charging_flag   = chg_q;
	assign shown_led       = led_q;

endmodule
